// File: rtl/core/modexp_pkg.sv
// modexp_pkg: shared constants for the modular exponentiation core.
// No dependencies; imported by modular_exponentiation.
`timescale 1ns / 1ps

package modexp_pkg;

   // modulus value after reset (1e9 + 7), cut to the operand width by the core
   localparam logic [63:0] RESET_MODULUS = 64'd1000000007;

   // register index of the modulus in the CSR map
   localparam int unsigned REG_MODULUS = 0;

endpackage

// File: rtl/core/modular_exponentiation.sv
// modular_exponentiation: right-to-left binary base^exponent mod modulus, one shared
// bit-serial modular multiply/accumulate unit; depends on modexp_pkg.
// Exponent zero: the result strobes in the cycle after start. Else: the base is reduced
// first unless the modulus is zero, then per bit a dispatch state and a multiply/square,
// no square after the top set bit, then the result strobe cycle.
// Start is accepted only while not busy; busy is high while a nonzero-exponent transaction is in work.
// Reset (synchronous) returns to idle and sets the modulus to 1e9+7 cut to the operand width; results cannot stall.
`timescale 1ns / 1ps

module modular_exponentiation
   import modexp_pkg::*;
#(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [OPERAND_WIDTH-1:0] req_base_value,
   input  logic [OPERAND_WIDTH-1:0] req_exponent,
   output logic                     rsp_valid,
   output logic [OPERAND_WIDTH-1:0] rsp_power_mod,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [((OPERAND_WIDTH > 32) ? 4 : 3)-1:0] csr_paddr,
   input  logic [((OPERAND_WIDTH > 32) ? 64 : 32)-1:0] csr_pwdata,
   output logic [((OPERAND_WIDTH > 32) ? 64 : 32)-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int W      = OPERAND_WIDTH;
   localparam int CSR_AW = (W > 32) ? 4 : 3;
   localparam int CSR_DW = (W > 32) ? 64 : 32;
   localparam int CNT_W  = $clog2(W);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RED  = 3'd1;
   localparam logic [2:0] ST_NEXT = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_SQR  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [W-1:0]     mod_ff, mod_in;
   logic [W-1:0]     mod_work_ff, mod_work_in;
   logic [W-1:0]     base_ff, base_in;
   logic [W-1:0]     exp_ff, exp_in;
   logic [W-1:0]     res_ff, res_in;
   logic [W-1:0]     acc_ff, acc_in;
   logic [W-1:0]     mul_x_ff, mul_x_in;
   logic [W-1:0]     mul_y_ff, mul_y_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic             csr_write;
   logic             csr_hit;
   logic             last_step;
   logic [W-1:0]     addend;
   logic [W+1:0]     sum, sum_m1, sum_m2, m_ext, m2_ext;
   logic [W-1:0]     step;
   logic [W-1:0]     exp_shr;

   assign busy          = (state_ff != ST_IDLE);
   assign accept        = start && !busy;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_power_mod = res_ff;

   // CSR port
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_AW-1] == 1'(REG_MODULUS));
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? CSR_DW'(mod_ff) : '0;
   assign mod_in     = csr_write ? csr_pwdata[W-1:0] : mod_ff;

   // shared unit: acc <- (2*acc + ybit*x) mod m, inputs below m so the sum is below 3m
   assign addend = mul_y_ff[W-1] ? mul_x_ff : '0;
   assign sum    = {1'b0, acc_ff, 1'b0} + {2'b00, addend};
   assign m_ext  = {2'b00, mod_work_ff};
   assign m2_ext = {1'b0, mod_work_ff, 1'b0};
   assign sum_m1 = sum - m_ext;
   assign sum_m2 = sum - m2_ext;

   always_comb begin
      if (mod_work_ff == '0) begin
         step = sum[W-1:0];
      end else if (sum >= m2_ext) begin
         step = sum_m2[W-1:0];
      end else if (sum >= m_ext) begin
         step = sum_m1[W-1:0];
      end else begin
         step = sum[W-1:0];
      end
   end

   assign last_step = (cnt_ff == '0);
   assign exp_shr   = exp_ff >> 1;

   always_comb begin
      state_in     = state_ff;
      mod_work_in  = mod_work_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      res_in       = res_ff;
      acc_in       = acc_ff;
      mul_x_in     = mul_x_ff;
      mul_y_in     = mul_y_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;

      unique case (state_ff) inside
         ST_IDLE: begin
            if (accept) begin
               base_in     = req_base_value;
               exp_in      = req_exponent;
               mod_work_in = mod_ff;
               if (req_exponent == '0) begin
                  res_in       = W'(1);
                  rsp_valid_in = 1'b1;
               end else begin
                  res_in = (mod_ff == W'(1)) ? '0 : W'(1);
                  if (mod_ff != '0) begin
                     acc_in   = '0;
                     mul_x_in = W'(1);
                     mul_y_in = req_base_value;
                     cnt_in   = CNT_W'(W - 1);
                     state_in = ST_RED;
                  end else begin
                     state_in = ST_NEXT;
                  end
               end
            end
         end
         ST_RED, ST_MUL, ST_SQR: begin
            acc_in   = step;
            mul_y_in = mul_y_ff << 1;
            cnt_in   = cnt_ff - 1'b1;
            if (last_step) begin
               acc_in = '0;
               cnt_in = CNT_W'(W - 1);
               if (state_ff == ST_RED) begin
                  base_in  = step;
                  state_in = ST_NEXT;
               end else if (state_ff == ST_MUL) begin
                  res_in = step;
                  if (exp_shr == '0) begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     mul_x_in = base_ff;
                     mul_y_in = base_ff;
                     state_in = ST_SQR;
                  end
               end else begin
                  base_in  = step;
                  exp_in   = exp_shr;
                  state_in = ST_NEXT;
               end
            end
         end
         ST_NEXT: begin
            acc_in = '0;
            cnt_in = CNT_W'(W - 1);
            if (exp_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (exp_ff[0]) begin
               mul_x_in = res_ff;
               mul_y_in = base_ff;
               state_in = ST_MUL;
            end else begin
               mul_x_in = base_ff;
               mul_y_in = base_ff;
               state_in = ST_SQR;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mod_ff       <= RESET_MODULUS[W-1:0];
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mod_ff       <= mod_in;
      end
   end

   always_ff @(posedge clock) begin
      mod_work_ff <= mod_work_in;
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      res_ff      <= res_in;
      acc_ff      <= acc_in;
      mul_x_ff    <= mul_x_in;
      mul_y_ff    <= mul_y_in;
      cnt_ff      <= cnt_in;
   end

`ifndef SYNTHESIS
   a_zero_exp: assert property (@(posedge clock) disable iff (reset)
      accept && (req_exponent == '0) |=> rsp_valid && (rsp_power_mod == W'(1)))
      else $error("exponent zero did not give 1");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept && (req_exponent != '0) |=> busy)
      else $error("nonzero exponent transaction did not raise busy");

   a_no_spurious_strobe: assert property (@(posedge clock) disable iff (reset)
      !busy && !accept |=> !rsp_valid)
      else $error("result strobe without a transaction");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RED) || (state_ff == ST_MUL) || (state_ff == ST_SQR))
      && (mod_work_ff != '0) |-> (acc_ff < mod_work_ff))
      else $error("accumulator not reduced below modulus");
`endif

endmodule
